// File: rtl/aipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aipd_pkg
// types, constants and round function shared by the pair difference pipeline
// ----------------------------------------------------------------------------
package aipd_pkg;

  localparam int WORD_W = 64;
  localparam int RND_W  = 4;   // holds any round count up to twelve
  localparam int RC_N   = 12;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [4:0]       state_t;

  typedef struct packed {
    state_t a;
    state_t b;
  } pair_t;

  typedef enum logic [1:0] {
    REG_KEY_HIGH    = 2'd0,
    REG_KEY_LOW     = 2'd1,
    REG_ROUND_COUNT = 2'd2
  } reg_idx_t;

  localparam logic [2:0]  ROUND_COUNT_RST = 3'd5;
  localparam word_t       ASCON_IV        = 64'h8040_0c06_0000_0000;

  localparam logic [7:0] RC_TABLE [RC_N] = '{
    8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
  };

  // bit n of a 128-bit value, numbered from the msb of the high word
  function automatic logic bit_at(input word_t hi, input word_t lo, input logic [6:0] n);
    logic [5:0] pos;
    pos = ~n[5:0];
    return n[6] ? lo[pos] : hi[pos];
  endfunction

  function automatic word_t rot_r(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // one ascon round; lin selects the linear diffusion layer
  function automatic state_t ascon_round(input state_t s, input logic [7:0] rc,
                                         input logic lin);
    state_t w;
    state_t t;
    state_t r;
    w = s;
    w[2] = w[2] ^ {56'd0, rc};
    w[0] = w[0] ^ w[4];
    w[4] = w[4] ^ w[3];
    w[2] = w[2] ^ w[1];
    t[0] = w[0] ^ (~w[1] & w[2]);
    t[1] = w[1] ^ (~w[2] & w[3]);
    t[2] = w[2] ^ (~w[3] & w[4]);
    t[3] = w[3] ^ (~w[4] & w[0]);
    t[4] = w[4] ^ (~w[0] & w[1]);
    t[1] = t[1] ^ t[0];
    t[0] = t[0] ^ t[4];
    t[3] = t[3] ^ t[2];
    t[2] = ~t[2];
    if (lin) begin
      r[0] = t[0] ^ rot_r(t[0], 19) ^ rot_r(t[0], 28);
      r[1] = t[1] ^ rot_r(t[1], 61) ^ rot_r(t[1], 39);
      r[2] = t[2] ^ rot_r(t[2], 1)  ^ rot_r(t[2], 6);
      r[3] = t[3] ^ rot_r(t[3], 10) ^ rot_r(t[3], 17);
      r[4] = t[4] ^ rot_r(t[4], 7)  ^ rot_r(t[4], 41);
    end else begin
      r = t;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ascon_init_pair_difference.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascon_init_pair_difference
// reduced-round ascon-128 initialisation difference for a nonce pair
// ----------------------------------------------------------------------------
// takes one 128-bit nonce per transfer and returns the five-word xor
// difference between two initialisation runs: the conditioned nonce with bit 7
// of bytes 0 and 8 cleared, and the same nonce with those bits set. the
// pipeline is MAX_ROUNDS + 2 register stages deep (conditioning, one stage per
// round, difference/output register). the conditioning stage loads at the
// input transfer edge, and a new nonce is taken every cycle unless an output
// stall has backed up the pipeline. each stage holds its own valid bit and
// only stalls when it is full and its successor cannot take its item, so
// bubbles are squeezed out while the output is stalled. round stages beyond
// round_count pass the state through; the stage for the final round leaves
// out the linear layer. round_count is clamped to MAX_ROUNDS. key and
// round_count must be written through the cfg port only while the pipeline
// is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ascon_init_pair_difference #(
  parameter int MAX_ROUNDS = 7
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // configuration
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire aipd_pkg::word_t cfg_data,
  // nonce input
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire aipd_pkg::word_t in_nonce_high,
  input  wire aipd_pkg::word_t in_nonce_low,
  // difference output
  output logic                 out_valid,
  input  wire logic            out_stall,
  output aipd_pkg::word_t      out_diff_word0,
  output aipd_pkg::word_t      out_diff_word1,
  output aipd_pkg::word_t      out_diff_word2,
  output aipd_pkg::word_t      out_diff_word3,
  output aipd_pkg::word_t      out_diff_word4
);
  import aipd_pkg::*;

  // configuration registers
  word_t            key_high_r;
  word_t            key_low_r;
  logic [2:0]       round_count_r;
  logic [RND_W-1:0] rounds_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r    <= '0;
      key_low_r     <= '0;
      round_count_r <= ROUND_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH:    key_high_r    <= cfg_data;
        REG_KEY_LOW:     key_low_r     <= cfg_data;
        REG_ROUND_COUNT: round_count_r <= cfg_data[2:0];
        default: ;       // unmapped index, write dropped
      endcase
    end
  end

  // clamp to the number of round stages built
  assign rounds_eff = ({1'b0, round_count_r} > RND_W'(MAX_ROUNDS)) ?
                      RND_W'(MAX_ROUNDS) : {1'b0, round_count_r};

  // stage links: index 0 is the conditioning output, index k+1 leaves round k
  pair_t stg_pair [MAX_ROUNDS+1];
  logic  stg_vld  [MAX_ROUNDS+1];
  logic  stg_rdy  [MAX_ROUNDS+1];
  logic  cond_rdy;

  aipd_cond u_cond (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_high   (key_high_r),
    .key_low    (key_low_r),
    .in_vld     (in_valid),
    .in_rdy     (cond_rdy),
    .nonce_high (in_nonce_high),
    .nonce_low  (in_nonce_low),
    .out_vld    (stg_vld[0]),
    .out_rdy    (stg_rdy[0]),
    .out_pair   (stg_pair[0])
  );

  assign in_stall = !cond_rdy;

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
    aipd_round #(
      .IDX (k)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .rounds   (rounds_eff),
      .in_vld   (stg_vld[k]),
      .in_rdy   (stg_rdy[k]),
      .in_pair  (stg_pair[k]),
      .out_vld  (stg_vld[k+1]),
      .out_rdy  (stg_rdy[k+1]),
      .out_pair (stg_pair[k+1])
    );
  end

  // output register: xor of the two finished states
  logic   out_valid_r;
  logic   out_load;
  state_t diff_r;
  state_t diff_nxt;

  assign out_load = !out_valid_r || !out_stall;
  assign stg_rdy[MAX_ROUNDS] = out_load;
  assign diff_nxt = stg_pair[MAX_ROUNDS].a ^ stg_pair[MAX_ROUNDS].b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= stg_vld[MAX_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stg_vld[MAX_ROUNDS]) begin
      diff_r <= diff_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_diff_word0 = diff_r[0];
  assign out_diff_word1 = diff_r[1];
  assign out_diff_word2 = diff_r[2];
  assign out_diff_word3 = diff_r[3];
  assign out_diff_word4 = diff_r[4];

endmodule
`default_nettype wire

// File: rtl/aipd_cond.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aipd_cond
// nonce conditioning stage: builds the initial state pair
// ----------------------------------------------------------------------------
module aipd_cond (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire aipd_pkg::word_t key_high,
  input  wire aipd_pkg::word_t key_low,
  input  wire logic            in_vld,
  output logic                 in_rdy,
  input  wire aipd_pkg::word_t nonce_high,
  input  wire aipd_pkg::word_t nonce_low,
  output logic                 out_vld,
  input  wire logic            out_rdy,
  output aipd_pkg::pair_t      out_pair
);
  import aipd_pkg::*;

  logic  vld_r;
  logic  load;
  pair_t pair_r;
  pair_t pair_nxt;
  word_t nh;
  word_t nl;
  logic  c2, c18, c89, c108, c117, c118;

  function automatic logic kb(input logic [6:0] n);
    return bit_at(key_high, key_low, n);
  endfunction

  function automatic logic nb(input logic [6:0] n);
    return bit_at(nonce_high, nonce_low, n);
  endfunction

  always_comb begin
    c89 = (kb(7'd3) & kb(7'd67)) ^ (kb(7'd3) & nb(7'd3)) ^ kb(7'd3)
        ^ (kb(7'd25) & kb(7'd89)) ^ (kb(7'd25) & nb(7'd25)) ^ kb(7'd25)
        ^ (kb(7'd67) & nb(7'd3)) ^ kb(7'd67) ^ (kb(7'd89) & nb(7'd25)) ^ kb(7'd89)
        ^ nb(7'd3) ^ nb(7'd25) ^ nb(7'd67) ^ 1'b1;
    c118 = (kb(7'd23) & nb(7'd87)) ^ kb(7'd23) ^ kb(7'd47) ^ kb(7'd54)
         ^ (kb(7'd57) & nb(7'd121)) ^ kb(7'd57) ^ kb(7'd111) ^ kb(7'd118)
         ^ nb(7'd23) ^ nb(7'd47) ^ nb(7'd54) ^ nb(7'd57) ^ nb(7'd87)
         ^ nb(7'd111) ^ nb(7'd121);
    c2 = kb(7'd2) ^ kb(7'd9) ^ (kb(7'd12) & nb(7'd76)) ^ kb(7'd12)
       ^ (kb(7'd19) & nb(7'd83)) ^ (kb(7'd42) & nb(7'd106)) ^ kb(7'd42)
       ^ kb(7'd66) ^ kb(7'd73) ^ kb(7'd83) ^ nb(7'd12) ^ nb(7'd42) ^ nb(7'd66)
       ^ nb(7'd76) ^ nb(7'd106);
    c108 = (kb(7'd19) & kb(7'd83)) ^ (kb(7'd19) & nb(7'd19)) ^ kb(7'd19)
         ^ (kb(7'd22) & kb(7'd86)) ^ (kb(7'd22) & nb(7'd22)) ^ kb(7'd22)
         ^ (kb(7'd44) & kb(7'd108)) ^ (kb(7'd44) & nb(7'd44)) ^ kb(7'd44)
         ^ (kb(7'd83) & nb(7'd19)) ^ kb(7'd83)
         ^ (kb(7'd86) & nb(7'd22)) ^ kb(7'd86)
         ^ (kb(7'd108) & nb(7'd44)) ^ kb(7'd108)
         ^ nb(7'd19) ^ nb(7'd22) ^ nb(7'd44) ^ nb(7'd83) ^ nb(7'd86);
    c117 = (kb(7'd28) & kb(7'd92)) ^ (kb(7'd28) & nb(7'd28)) ^ kb(7'd28)
         ^ (kb(7'd31) & kb(7'd95)) ^ (kb(7'd31) & nb(7'd31)) ^ kb(7'd31)
         ^ (kb(7'd53) & kb(7'd117)) ^ (kb(7'd53) & nb(7'd53)) ^ kb(7'd53)
         ^ (kb(7'd92) & nb(7'd28)) ^ kb(7'd92)
         ^ (kb(7'd95) & nb(7'd31)) ^ kb(7'd95)
         ^ (kb(7'd117) & nb(7'd53)) ^ kb(7'd117)
         ^ nb(7'd28) ^ nb(7'd31) ^ nb(7'd53) ^ nb(7'd92) ^ nb(7'd95);
    c18 = kb(7'd11) ^ kb(7'd18) ^ (kb(7'd21) & nb(7'd85)) ^ (kb(7'd28) & nb(7'd92))
        ^ (kb(7'd51) & nb(7'd115)) ^ kb(7'd51) ^ kb(7'd75) ^ kb(7'd82) ^ kb(7'd92)
        ^ nb(7'd11) ^ nb(7'd21) ^ nb(7'd51) ^ nb(7'd75) ^ nb(7'd82) ^ nb(7'd85)
        ^ nb(7'd115) ^ 1'b1;

    // bit n sits at hi[63-n] or lo[127-n]
    nh = nonce_high;
    nl = nonce_low;
    nh[63] = 1'b0;       // bit 0
    nl[63] = 1'b0;       // bit 64
    nh[61] = c2;
    nl[38] = c89;
    nl[19] = c108;
    nl[10] = c117;
    nl[9]  = c118;
    nh[45] = c18;

    pair_nxt.a = {nl, nh, key_low, key_high, ASCON_IV};
    pair_nxt.b = pair_nxt.a;
    pair_nxt.b[3][63] = 1'b1;
    pair_nxt.b[4][63] = 1'b1;
  end

  assign load    = !vld_r || out_rdy;
  assign in_rdy  = load;
  assign out_vld = vld_r;
  assign out_pair = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_vld) begin
      pair_r <= pair_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/aipd_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aipd_round
// one round stage for both states of the pair
// ----------------------------------------------------------------------------
module aipd_round #(
  parameter int IDX = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [aipd_pkg::RND_W-1:0] rounds,
  input  wire logic                       in_vld,
  output logic                            in_rdy,
  input  wire aipd_pkg::pair_t            in_pair,
  output logic                            out_vld,
  input  wire logic                       out_rdy,
  output aipd_pkg::pair_t                 out_pair
);
  import aipd_pkg::*;

  localparam logic [RND_W-1:0] IDX_V  = RND_W'(IDX);
  localparam logic [RND_W-1:0] NEXT_V = RND_W'(IDX + 1);
  localparam logic [7:0]       RC     = RC_TABLE[IDX];

  logic  vld_r;
  logic  load;
  logic  active;
  logic  lin;
  pair_t pair_r;
  pair_t pair_nxt;

  assign active = IDX_V < rounds;
  assign lin    = NEXT_V < rounds;

  always_comb begin
    if (active) begin
      pair_nxt.a = ascon_round(in_pair.a, RC, lin);
      pair_nxt.b = ascon_round(in_pair.b, RC, lin);
    end else begin
      pair_nxt = in_pair;
    end
  end

  assign load     = !vld_r || out_rdy;
  assign in_rdy   = load;
  assign out_vld  = vld_r;
  assign out_pair = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_vld) begin
      pair_r <= pair_nxt;
    end
  end

endmodule
`default_nettype wire
